FILE: sv/pid_controller_step_assert.svh
// assertion macros shared by the pid step block
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// same-cycle implication, checked on clk with reset masked
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/pidc_pkg.sv
// shared types, constants, microcode program and arithmetic helpers of the pid step block
`default_nettype none

package pidc_pkg;

	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int FRAC_BITS   = 16;
	localparam int DEG_SHIFT   = 24;
	localparam int GAIN_W      = 31;
	localparam int PERIOD_W    = 16;
	localparam int REQ_W       = 2;
	localparam int ADDR_W      = 5;
	localparam int REG_IDX_LSB = 2;
	localparam int REG_IDX_W   = 3;
	localparam int UPC_W       = 4;

	// 180/pi as unsigned Q7.24
	localparam logic [GAIN_W-1:0] RAD2DEG_Q24 = 31'd961263669;

	localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};

	// -50.0 and 50.0 in Q16.16
	localparam logic signed [DATA_W-1:0] OUT_MIN_RST = -32'sd3276800;
	localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd3276800;
	localparam logic [PERIOD_W-1:0]      PERIOD_RST  = 16'd10;

	localparam logic [UPC_W-1:0] UPC_INIT = 4'd9;

	typedef enum logic [REQ_W-1:0] {
		REQ_TIMED  = 2'd0,
		REQ_DIRECT = 2'd1,
		REQ_INIT   = 2'd2
	} req_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_OUT_MIN     = 3'd3,
		REG_OUT_MAX     = 3'd4,
		REG_PERIOD      = 3'd5,
		REG_REVERSE     = 3'd6,
		REG_AUTO_MODE   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} flow_state_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_RAD_DEG,
		MUL_KP_ERR,
		MUL_KI_ERR,
		MUL_KD_DIN
	} mul_sel_t;

	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_DEG,
		ALU_ERR_DIN,
		ALU_PROP,
		ALU_IPART,
		ALU_DERIV,
		ALU_INTEG,
		ALU_DRIVE,
		ALU_INIT
	} alu_op_t;

	typedef enum logic {
		JMP_NONE,
		JMP_IF_INIT
	} jmp_t;

	typedef struct packed {
		mul_sel_t           mul_sel;
		alu_op_t            alu_op;
		jmp_t               jmp;
		logic [UPC_W-1:0]   target;
		logic               last;
	} ucode_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		alu_op_t  alu_op;
	} seq_ctl_t;

	typedef struct packed {
		logic [GAIN_W-1:0]          prop_gain;
		logic [GAIN_W-1:0]          integ_gain;
		logic [GAIN_W-1:0]          deriv_gain;
		logic signed [DATA_W-1:0]   out_min;
		logic signed [DATA_W-1:0]   out_max;
		logic [PERIOD_W-1:0]        sample_period;
		logic                       reverse_acting;
		logic                       auto_mode;
	} cfg_t;

	typedef struct packed {
		logic                       valid;
		logic signed [DATA_W-1:0]   lo;
		logic signed [DATA_W-1:0]   hi;
	} lim_upd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] prop;
		logic signed [DATA_W-1:0] integ;
		logic signed [DATA_W-1:0] deriv;
	} dp_view_t;

	// control store: compute runs 0..8, initialize branches off after the degree step
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t w;
		unique case (upc)
			4'd0:    w = '{MUL_RAD_DEG, ALU_NOP,     JMP_NONE,    '0,       1'b0};
			4'd1:    w = '{MUL_NONE,    ALU_DEG,     JMP_IF_INIT, UPC_INIT, 1'b0};
			4'd2:    w = '{MUL_NONE,    ALU_ERR_DIN, JMP_NONE,    '0,       1'b0};
			4'd3:    w = '{MUL_KP_ERR,  ALU_NOP,     JMP_NONE,    '0,       1'b0};
			4'd4:    w = '{MUL_KI_ERR,  ALU_PROP,    JMP_NONE,    '0,       1'b0};
			4'd5:    w = '{MUL_KD_DIN,  ALU_IPART,   JMP_NONE,    '0,       1'b0};
			4'd6:    w = '{MUL_NONE,    ALU_DERIV,   JMP_NONE,    '0,       1'b0};
			4'd7:    w = '{MUL_NONE,    ALU_INTEG,   JMP_NONE,    '0,       1'b0};
			4'd8:    w = '{MUL_NONE,    ALU_DRIVE,   JMP_NONE,    '0,       1'b1};
			4'd9:    w = '{MUL_NONE,    ALU_INIT,    JMP_NONE,    '0,       1'b1};
			default: w = '{MUL_NONE,    ALU_NOP,     JMP_NONE,    '0,       1'b1};
		endcase
		return w;
	endfunction

	function automatic logic signed [PROD_W-1:0] sx(input logic signed [DATA_W-1:0] v);
		return PROD_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] x);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = sx(SAT_HI);
		lo = sx(SAT_LO);
		if (x > hi) begin
			return SAT_HI;
		end else if (x < lo) begin
			return SAT_LO;
		end
		return x[DATA_W-1:0];
	endfunction

	// round to nearest, halves toward plus infinity
	function automatic logic signed [PROD_W-1:0] round_shr(input logic signed [PROD_W-1:0] x,
		input int unsigned s);
		logic signed [PROD_W-1:0] half;
		logic signed [PROD_W-1:0] sum;
		half = {{(PROD_W-1){1'b0}}, 1'b1} << (s - 1);
		sum  = x + half;
		return sum >>> s;
	endfunction

	function automatic logic signed [DATA_W-1:0] gain_post(input logic signed [PROD_W-1:0] prod,
		input logic rev);
		logic signed [PROD_W-1:0] r;
		r = round_shr(prod, FRAC_BITS);
		if (rev) begin
			r = -r;
		end
		return sat_prod(r);
	endfunction

	// above max wins over below min when the limits cross
	function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [PROD_W-1:0] x,
		input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		if (x > sx(hi)) begin
			return hi;
		end else if (x < sx(lo)) begin
			return lo;
		end
		return x[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/pidc_in_if.sv
// request channel: valid/ready plus one request transaction
`default_nettype none

interface pidc_in_if;
	import pidc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic signed [DATA_W-1:0]   measured_rad;
	logic signed [DATA_W-1:0]   setpoint_deg;
	logic [DATA_W-1:0]          now_ms;
	logic signed [DATA_W-1:0]   manual_output;

	modport source (
		output valid, req_type, measured_rad, setpoint_deg, now_ms, manual_output,
		input  ready
	);

	modport sink (
		input  valid, req_type, measured_rad, setpoint_deg, now_ms, manual_output,
		output ready
	);

endinterface

`default_nettype wire

FILE: sv/pidc_out_if.sv
// result channel: valid/ready plus one result transaction
`default_nettype none

interface pidc_out_if;
	import pidc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       computed;
	logic signed [DATA_W-1:0]   drive;
	logic signed [DATA_W-1:0]   prop_term;
	logic signed [DATA_W-1:0]   integ_term;
	logic signed [DATA_W-1:0]   deriv_term;

	modport source (
		output valid, computed, drive, prop_term, integ_term, deriv_term,
		input  ready
	);

	modport sink (
		input  valid, computed, drive, prop_term, integ_term, deriv_term,
		output ready
	);

endinterface

`default_nettype wire

FILE: sv/pidc_regs.sv
// apb configuration register file of the pid step block
`default_nettype none

module pidc_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pidc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pidc_pkg::DATA_W-1:0] pwdata,
	output logic [pidc_pkg::DATA_W-1:0]      prdata,
	output pidc_pkg::cfg_t                   cfg,
	output pidc_pkg::lim_upd_t               lim
);
	import pidc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[REG_IDX_LSB +: REG_IDX_W]);
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= '0;
			cfg_q.integ_gain     <= '0;
			cfg_q.deriv_gain     <= '0;
			cfg_q.out_min        <= OUT_MIN_RST;
			cfg_q.out_max        <= OUT_MAX_RST;
			cfg_q.sample_period  <= PERIOD_RST;
			cfg_q.reverse_acting <= 1'b0;
			cfg_q.auto_mode      <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_PROP_GAIN:  cfg_q.prop_gain      <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN: cfg_q.integ_gain     <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain     <= pwdata[GAIN_W-1:0];
				REG_OUT_MIN:    cfg_q.out_min        <= pwdata;
				REG_OUT_MAX:    cfg_q.out_max        <= pwdata;
				REG_PERIOD:     cfg_q.sample_period  <= pwdata[PERIOD_W-1:0];
				REG_REVERSE:    cfg_q.reverse_acting <= pwdata[0];
				REG_AUTO_MODE:  cfg_q.auto_mode      <= pwdata[0];
			endcase
		end
	end

	// new limits go to the datapath in the write cycle so the clamp sees them
	always_comb begin
		lim.valid = wr && cfg_q.auto_mode && (idx == REG_OUT_MIN || idx == REG_OUT_MAX);
		lim.lo    = (idx == REG_OUT_MIN) ? pwdata : cfg_q.out_min;
		lim.hi    = (idx == REG_OUT_MAX) ? pwdata : cfg_q.out_max;
	end

	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:  prdata = DATA_W'(cfg_q.prop_gain);
			REG_INTEG_GAIN: prdata = DATA_W'(cfg_q.integ_gain);
			REG_DERIV_GAIN: prdata = DATA_W'(cfg_q.deriv_gain);
			REG_OUT_MIN:    prdata = cfg_q.out_min;
			REG_OUT_MAX:    prdata = cfg_q.out_max;
			REG_PERIOD:     prdata = DATA_W'(cfg_q.sample_period);
			REG_REVERSE:    prdata = DATA_W'(cfg_q.reverse_acting);
			REG_AUTO_MODE:  prdata = DATA_W'(cfg_q.auto_mode);
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/pidc_seq.sv
// microcode sequencer: step counter, control store and conditional jump
`default_nettype none

module pidc_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          init_mode,
	output pidc_pkg::seq_ctl_t ctl,
	output logic               busy,
	output logic               done
);
	import pidc_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             busy_q;
	logic             init_q;
	ucode_t           word;

	assign word = ucode_rom(upc_q);
	assign busy = busy_q;
	assign done = busy_q & word.last;

	always_comb begin
		ctl.mul_sel = MUL_NONE;
		ctl.alu_op  = ALU_NOP;
		if (busy_q) begin
			ctl.mul_sel = word.mul_sel;
			ctl.alu_op  = word.alu_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= '0;
			busy_q <= 1'b0;
			init_q <= 1'b0;
		end else if (start) begin
			upc_q  <= '0;
			busy_q <= 1'b1;
			init_q <= init_mode;
		end else if (busy_q) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else if (word.jmp == JMP_IF_INIT && init_q) begin
				upc_q <= word.target;
			end else begin
				upc_q <= upc_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/pidc_dp.sv
// pid datapath: shared multiplier, rounding/saturation unit and state registers
`default_nettype none

module pidc_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pidc_pkg::cfg_t                    cfg,
	input  wire pidc_pkg::lim_upd_t                lim,
	input  wire pidc_pkg::seq_ctl_t                ctl,
	input  wire logic                              load,
	input  wire logic signed [pidc_pkg::DATA_W-1:0] rad,
	input  wire logic signed [pidc_pkg::DATA_W-1:0] sp,
	input  wire logic signed [pidc_pkg::DATA_W-1:0] man,
	output pidc_pkg::dp_view_t                     view
);
	import pidc_pkg::*;

	// operands latched from the request
	logic signed [DATA_W-1:0] rad_q, sp_q, man_q;
	// scratch
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] in_deg_q, err_q, din_q, p_q, t_q, d_q;
	// architectural state
	logic signed [DATA_W-1:0] integ_q, prev_q, drive_q, prop_q, deriv_q;

	logic [GAIN_W-1:0]        mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [DATA_W-1:0] post;

	assign view.drive = drive_q;
	assign view.prop  = prop_q;
	assign view.integ = integ_q;
	assign view.deriv = deriv_q;

	always_comb begin
		mul_a = RAD2DEG_Q24;
		mul_b = rad_q;
		unique case (ctl.mul_sel)
			MUL_NONE,
			MUL_RAD_DEG: begin
				mul_a = RAD2DEG_Q24;
				mul_b = rad_q;
			end
			MUL_KP_ERR: begin
				mul_a = cfg.prop_gain;
				mul_b = err_q;
			end
			MUL_KI_ERR: begin
				mul_a = cfg.integ_gain;
				mul_b = err_q;
			end
			MUL_KD_DIN: begin
				mul_a = cfg.deriv_gain;
				mul_b = din_q;
			end
			default: begin
				mul_a = RAD2DEG_Q24;
				mul_b = rad_q;
			end
		endcase
	end

	assign post = gain_post(prod_q, cfg.reverse_acting);

	always_ff @(posedge clk) begin
		if (load) begin
			rad_q <= rad;
			sp_q  <= sp;
			man_q <= man;
		end
		if (ctl.mul_sel != MUL_NONE) begin
			prod_q <= $signed({1'b0, mul_a}) * mul_b;
		end
		unique case (ctl.alu_op)
			ALU_DEG:     in_deg_q <= sat_prod(round_shr(prod_q, DEG_SHIFT));
			ALU_ERR_DIN: begin
				err_q <= sat_prod(sx(sp_q) - sx(in_deg_q));
				din_q <= sat_prod(sx(in_deg_q) - sx(prev_q));
			end
			ALU_PROP:    p_q <= post;
			ALU_IPART:   t_q <= post;
			ALU_DERIV:   d_q <= sat_prod(-sx(post));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			drive_q <= '0;
			prop_q  <= '0;
			deriv_q <= '0;
		end else if (lim.valid) begin
			integ_q <= clamp_lim(sx(integ_q), lim.lo, lim.hi);
			drive_q <= clamp_lim(sx(drive_q), lim.lo, lim.hi);
		end else begin
			unique case (ctl.alu_op)
				ALU_INTEG: begin
					integ_q <= clamp_lim(sx(integ_q) + sx(t_q), cfg.out_min, cfg.out_max);
				end
				ALU_DRIVE: begin
					drive_q <= clamp_lim(sx(p_q) + sx(integ_q) + sx(d_q),
						cfg.out_min, cfg.out_max);
					prop_q  <= p_q;
					deriv_q <= d_q;
					prev_q  <= in_deg_q;
				end
				ALU_INIT: begin
					integ_q <= clamp_lim(sx(man_q), cfg.out_min, cfg.out_max);
					prev_q  <= in_deg_q;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/pid_controller_step.sv
// pid step top level: a compute transaction runs the 9-step microcode program on the single
// shared multiplier, an initialize transaction a shorter branch of it, and a transaction
// that computes nothing skips the sequencer; the next request is taken once the result
// sits in the output register, so no new request is accepted while one is in flight.
// arst_n clears control, integral, last input, held terms and the timer; the first timed
// request in auto mode after reset always computes.
`default_nettype none

`include "pid_controller_step_assert.svh"

module pid_controller_step (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pidc_in_if.sink                          in_ch,
	pidc_out_if.source                       out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pidc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pidc_pkg::DATA_W-1:0]  pwdata,
	output logic [pidc_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import pidc_pkg::*;

	flow_state_t state_q, state_d;

	cfg_t      cfg;
	lim_upd_t  lim;
	seq_ctl_t  ctl;
	dp_view_t  view;

	logic seq_busy, seq_done, seq_start;

	// request decode in the accept cycle
	logic              acc;
	logic [DATA_W-1:0] elapsed;
	logic              is_timed, is_direct, is_init;
	logic              due, do_comp;

	// sample timer
	logic [DATA_W-1:0] last_ms_q;
	logic              first_q;

	// result register, parts the request side from the result side
	logic out_load;
	logic out_valid_q;
	logic comp_q;

	assign pready = 1'b1;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.lim     (lim)
	);

	assign acc       = in_ch.valid & in_ch.ready;
	assign is_timed  = in_ch.req_type == REQ_TIMED;
	assign is_direct = in_ch.req_type == REQ_DIRECT;
	assign is_init   = in_ch.req_type == REQ_INIT;
	// modular difference handles timestamp wrap
	assign elapsed   = in_ch.now_ms - last_ms_q;
	assign due       = first_q || (elapsed >= DATA_W'(cfg.sample_period));
	assign do_comp   = cfg.auto_mode && ((is_timed && due) || is_direct);
	// reserved request code, timed requests not yet due and manual-mode computes go straight to the result
	assign seq_start = acc && (do_comp || is_init);

	pidc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (seq_start),
		.init_mode (is_init),
		.ctl       (ctl),
		.busy      (seq_busy),
		.done      (seq_done)
	);

	pidc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.lim    (lim),
		.ctl    (ctl),
		.load   (acc),
		.rad    (in_ch.measured_rad),
		.sp     (in_ch.setpoint_deg),
		.man    (in_ch.manual_output),
		.view   (view)
	);

	// timed compute restarts the sample window; direct compute leaves it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ms_q <= '0;
			first_q   <= 1'b1;
		end else if (acc && is_timed && cfg.auto_mode && due) begin
			last_ms_q <= in_ch.now_ms;
			first_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (acc) begin
					state_d = seq_start ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (seq_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// computed flag captured at accept, held through the microcode run
	always_ff @(posedge clk) begin
		if (acc) begin
			comp_q <= do_comp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.computed   <= comp_q;
			out_ch.drive      <= view.drive;
			out_ch.prop_term  <= view.prop;
			out_ch.integ_term <= view.integ;
			out_ch.deriv_term <= view.deriv;
		end
	end

	assign out_ch.valid = out_valid_q;

	// a new request never lands on a running program or a pending result load
	`PIDC_ASSERT_NOW(a_accept_quiet, acc, !seq_busy && !out_load, "request accepted while busy")
	// the run state always has the sequencer stepping
	`PIDC_ASSERT_NOW(a_run_busy, state_q == ST_RUN, seq_busy, "run state without sequencer")
	// end of program hands over to the result stage and stops the sequencer
	`PIDC_ASSERT_NEXT(a_done_next, seq_done, state_q == ST_DONE && !seq_busy, "bad program end")

endmodule

`default_nettype wire

FILE: sim/pid_controller_step_tb.sv
// self-checking testbench for the pid step block: request and result channels plus apb setup
`timescale 1ns / 1ps

import pidc_pkg::*;

typedef struct packed {
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] measured_rad;
	logic signed [DATA_W-1:0] setpoint_deg;
	logic [DATA_W-1:0]        now_ms;
	logic signed [DATA_W-1:0] manual_output;
} pid_req_t;

typedef struct packed {
	logic                     computed;
	logic signed [DATA_W-1:0] drive;
	logic signed [DATA_W-1:0] prop_term;
	logic signed [DATA_W-1:0] integ_term;
	logic signed [DATA_W-1:0] deriv_term;
} pid_result_t;

// tracks controller state and configuration, queues the result each request should produce
class pid_loop_predictor;
	logic [GAIN_W-1:0]   kp;
	logic [GAIN_W-1:0]   ki_ts;
	logic [GAIN_W-1:0]   kd_ts;
	longint              lim_lo;
	longint              lim_hi;
	logic [PERIOD_W-1:0] period_ms;
	bit                  reverse;
	bit                  auto_on;
	longint              integ_acc;
	longint              prev_deg;
	longint              held_drive;
	longint              held_prop;
	longint              held_deriv;
	logic [DATA_W-1:0]   last_ms;
	bit                  first_due;
	pid_result_t         expected_results[$];
	int                  mismatches;

	function new();
		kp         = '0;
		ki_ts      = '0;
		kd_ts      = '0;
		lim_lo     = OUT_MIN_RST;
		lim_hi     = OUT_MAX_RST;
		period_ms  = PERIOD_RST;
		reverse    = 1'b0;
		auto_on    = 1'b1;
		integ_acc  = 0;
		prev_deg   = 0;
		held_drive = 0;
		held_prop  = 0;
		held_deriv = 0;
		last_ms    = '0;
		first_due  = 1'b1;
		mismatches = 0;
	endfunction

	function longint sat32(longint x);
		if (x > longint'(SAT_HI)) begin
			return longint'(SAT_HI);
		end else if (x < longint'(SAT_LO)) begin
			return longint'(SAT_LO);
		end
		return x;
	endfunction

	// max is tested first so crossed limits resolve to out_max
	function longint clamp_out(longint x);
		if (x > lim_hi) begin
			return lim_hi;
		end else if (x < lim_lo) begin
			return lim_lo;
		end
		return x;
	endfunction

	// nearest, halves up: arithmetic shift floors
	function longint round_shift(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function longint gain_scale(logic [GAIN_W-1:0] g, longint x);
		longint gl;
		longint p;
		gl = g;
		p = round_shift(gl * x, FRAC_BITS);
		if (reverse) begin
			p = -p;
		end
		return sat32(p);
	endfunction

	function longint to_degrees(longint rad);
		longint c;
		c = RAD2DEG_Q24;
		return sat32(round_shift(rad * c, DEG_SHIFT));
	endfunction

	function void run_compute(longint rad, longint sp);
		longint deg;
		longint err;
		longint din;
		longint p;
		longint d;
		deg = to_degrees(rad);
		err = sat32(sp - deg);
		din = sat32(deg - prev_deg);
		p = gain_scale(kp, err);
		d = sat32(-gain_scale(kd_ts, din));
		integ_acc  = clamp_out(integ_acc + gain_scale(ki_ts, err));
		held_drive = sat32(clamp_out(p + integ_acc + d));
		held_prop  = p;
		held_deriv = d;
		prev_deg   = deg;
	endfunction

	function void set_register(reg_idx_t idx, logic [DATA_W-1:0] value);
		logic signed [DATA_W-1:0] lim;
		lim = value;
		case (idx)
			REG_PROP_GAIN:  kp = value[GAIN_W-1:0];
			REG_INTEG_GAIN: ki_ts = value[GAIN_W-1:0];
			REG_DERIV_GAIN: kd_ts = value[GAIN_W-1:0];
			REG_OUT_MIN, REG_OUT_MAX: begin
				if (idx == REG_OUT_MIN) begin
					lim_lo = lim;
				end else begin
					lim_hi = lim;
				end
				if (auto_on) begin
					held_drive = clamp_out(held_drive);
					integ_acc  = clamp_out(integ_acc);
				end
			end
			REG_PERIOD:     period_ms = value[PERIOD_W-1:0];
			REG_REVERSE:    reverse = value[0];
			REG_AUTO_MODE:  auto_on = value[0];
			default: ;
		endcase
	endfunction

	function void take_request(pid_req_t r);
		logic [DATA_W-1:0] elapsed;
		bit                did;
		pid_result_t       e;
		did = 1'b0;
		if (r.req_type == REQ_TIMED && auto_on) begin
			elapsed = r.now_ms - last_ms;
			if (first_due || elapsed >= period_ms) begin
				run_compute(r.measured_rad, r.setpoint_deg);
				last_ms   = r.now_ms;
				first_due = 1'b0;
				did       = 1'b1;
			end
		end else if (r.req_type == REQ_DIRECT && auto_on) begin
			run_compute(r.measured_rad, r.setpoint_deg);
			did = 1'b1;
		end else if (r.req_type == REQ_INIT) begin
			integ_acc = clamp_out(r.manual_output);
			prev_deg  = to_degrees(r.measured_rad);
		end
		e.computed   = did;
		e.drive      = held_drive[DATA_W-1:0];
		e.prop_term  = held_prop[DATA_W-1:0];
		e.integ_term = integ_acc[DATA_W-1:0];
		e.deriv_term = held_deriv[DATA_W-1:0];
		expected_results.push_back(e);
	endfunction

	function void check_field(string name, logic signed [DATA_W-1:0] want,
		logic signed [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function void match_result(pid_result_t got);
		pid_result_t want;
		if (expected_results.size() == 0) begin
			$error("result transaction with no request pending: drive %0d", got.drive);
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		check_field("computed", want.computed, got.computed);
		check_field("drive", want.drive, got.drive);
		check_field("prop_term", want.prop_term, got.prop_term);
		check_field("integ_term", want.integ_term, got.integ_term);
		check_field("deriv_term", want.deriv_term, got.deriv_term);
	endfunction
endclass

module pid_controller_step_tb;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 4;
	// no transaction for this long means the block is stuck
	localparam int STALL_LIMIT  = 2000;
	// margin after the last result, to catch stray results
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_ITEMS = 1000;
	localparam int BLOCK_ITEMS  = 40;

	// request code the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// handy q16.16 values
	localparam logic signed [DATA_W-1:0] ONE_Q    = 32'sd65536;
	localparam logic signed [DATA_W-1:0] MAX_Q    = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] MIN_Q    = 32'sh80000000;
	localparam int                       RAD_SPAN = 205887;   // pi
	localparam int                       DEG_SPAN = 11796480; // 180 degrees
	localparam int                       MAN_SPAN = 3932160;  // 60.0
	localparam logic [GAIN_W-1:0]        GAIN_MAX = '1;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	pidc_in_if  req_ch();
	pidc_out_if rsp_ch();

	pid_loop_predictor loop_model;

	// per-cycle idle odds in percent for each side
	int                tx_idle_pct = 6;
	int                rx_idle_pct = 48;
	int                stall_cycles = 0;
	// running millisecond clock used by the random requests
	logic [DATA_W-1:0] clock_ms = '0;

	pid_controller_step u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (req_ch),
		.out_ch  (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver stalls at random, odds set per phase
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result check and stall watchdog, sampled at the edge before any update lands
	always @(posedge clk) begin
		pid_result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.computed   = rsp_ch.computed;
			got.drive      = rsp_ch.drive;
			got.prop_term  = rsp_ch.prop_term;
			got.integ_term = rsp_ch.integ_term;
			got.deriv_term = rsp_ch.deriv_term;
			loop_model.match_result(got);
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("pid_controller_step_tb: FAIL");
			$finish;
		end
	end

	// apb write: setup phase, then access phase until pready, then psel and penable drop
	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, {REG_IDX_LSB{1'b0}}};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		loop_model.set_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one request transaction, with random idle cycles ahead of it
	task automatic send_request(input pid_req_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= r.req_type;
		req_ch.measured_rad  <= r.measured_rad;
		req_ch.setpoint_deg  <= r.setpoint_deg;
		req_ch.now_ms        <= r.now_ms;
		req_ch.manual_output <= r.manual_output;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		loop_model.take_request(r);
	endtask

	// drop valid and let every outstanding result come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (loop_model.expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic pid_req_t make_req(input logic [REQ_W-1:0] kind,
		input logic signed [DATA_W-1:0] rad, input logic signed [DATA_W-1:0] sp,
		input logic [DATA_W-1:0] now, input logic signed [DATA_W-1:0] man);
		pid_req_t r;
		r.req_type      = kind;
		r.measured_rad  = rad;
		r.setpoint_deg  = sp;
		r.now_ms        = now;
		r.manual_output = man;
		return r;
	endfunction

	// mostly moderate gains, now and then zero, full scale or any 31-bit value
	function automatic logic [GAIN_W-1:0] pick_gain();
		logic [GAIN_W-1:0] g;
		case ($urandom_range(9))
			0:       g = '0;
			1:       g = GAIN_MAX;
			2:       g = GAIN_W'($urandom);
			default: g = GAIN_W'($urandom_range(0, 3 * 65536));
		endcase
		return g;
	endfunction

	// new controller setting between blocks of random transactions
	task automatic randomize_config();
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic [PERIOD_W-1:0]      period;
		case ($urandom_range(9))
			0: begin
				lo = MIN_Q;
				hi = MAX_Q;
			end
			1: begin
				// crossed limits
				lo = $urandom_range(ONE_Q, 20 * ONE_Q);
				hi = -$urandom_range(ONE_Q, 20 * ONE_Q);
			end
			2: begin
				lo = $urandom;
				hi = $urandom;
			end
			default: begin
				lo = -$urandom_range(ONE_Q, 200 * ONE_Q);
				hi = $urandom_range(ONE_Q, 200 * ONE_Q);
			end
		endcase
		case ($urandom_range(9))
			0:       period = '0;
			1:       period = '1;
			default: period = PERIOD_W'($urandom_range(1, 20));
		endcase
		apb_write(REG_PROP_GAIN, {1'b0, pick_gain()});
		apb_write(REG_INTEG_GAIN, {1'b0, pick_gain()});
		apb_write(REG_DERIV_GAIN, {1'b0, pick_gain()});
		apb_write(REG_OUT_MIN, lo);
		apb_write(REG_OUT_MAX, hi);
		apb_write(REG_PERIOD, DATA_W'(period));
		apb_write(REG_REVERSE, $urandom_range(1));
		apb_write(REG_AUTO_MODE, DATA_W'($urandom_range(9) != 0));
	endtask

	// mostly timed requests on a clock that steps around the sample period, plus
	// direct, initialize and ignored codes; values mostly in the physical range
	function automatic pid_req_t random_req();
		int                       sel;
		logic [REQ_W-1:0]         kind;
		logic signed [DATA_W-1:0] rad;
		logic signed [DATA_W-1:0] sp;
		logic signed [DATA_W-1:0] man;
		sel = $urandom_range(99);
		if (sel < 60) begin
			kind = REQ_TIMED;
		end else if (sel < 82) begin
			kind = REQ_DIRECT;
		end else if (sel < 96) begin
			kind = REQ_INIT;
		end else begin
			kind = REQ_UNUSED;
		end
		case ($urandom_range(19))
			0:       clock_ms = $urandom;
			1:       clock_ms = 32'hffffffff - $urandom_range(30);
			default: clock_ms = clock_ms + $urandom_range(0, 2 * loop_model.period_ms + 2);
		endcase
		if ($urandom_range(4) == 0) begin
			rad = $urandom;
		end else begin
			rad = $urandom_range(0, 2 * RAD_SPAN);
			rad = rad - RAD_SPAN;
		end
		if ($urandom_range(4) == 0) begin
			sp = $urandom;
		end else begin
			sp = $urandom_range(0, 2 * DEG_SPAN);
			sp = sp - DEG_SPAN;
		end
		if ($urandom_range(2) == 0) begin
			man = $urandom;
		end else begin
			man = $urandom_range(0, 2 * MAN_SPAN);
			man = man - MAN_SPAN;
		end
		return make_req(kind, rad, sp, clock_ms, man);
	endfunction

	initial begin
		loop_model = new();
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= '0;
		req_ch.measured_rad   <= '0;
		req_ch.setpoint_deg   <= '0;
		req_ch.now_ms         <= '0;
		req_ch.manual_output  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: first timed request fires early, then the period gates
		send_request(make_req(REQ_TIMED, RAD_SPAN / 4, ONE_Q, 32'd3, '0));
		send_request(make_req(REQ_TIMED, RAD_SPAN / 4, ONE_Q, 32'd9, '0));
		send_request(make_req(REQ_TIMED, RAD_SPAN / 4, ONE_Q, 32'd13, '0));
		wait_idle();

		apb_write(REG_PROP_GAIN, ONE_Q);
		apb_write(REG_INTEG_GAIN, 32'd6554);
		apb_write(REG_DERIV_GAIN, 32'd32768);

		// direct requests, including saturation of degrees, error and change
		send_request(make_req(REQ_DIRECT, RAD_SPAN / 2, DEG_SPAN / 2, 32'd14, '0));
		send_request(make_req(REQ_DIRECT, MAX_Q, MIN_Q, 32'd14, '0));
		send_request(make_req(REQ_DIRECT, MIN_Q, MAX_Q, 32'd14, '0));
		// timed across the 32-bit wrap of the millisecond counter
		send_request(make_req(REQ_TIMED, 32'sd1000, 32'sd0, 32'hfffffff8, '0));
		send_request(make_req(REQ_TIMED, -32'sd1000, 32'sd0, 32'd2, '0));
		// initialize with manual values beyond both limits
		send_request(make_req(REQ_INIT, '0, '0, 32'd2, MAX_Q));
		send_request(make_req(REQ_INIT, RAD_SPAN, '0, 32'd2, MIN_Q));
		// unused request code is ignored
		send_request(make_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom));
		wait_idle();

		// manual mode: computes nothing, initialize still acts
		apb_write(REG_AUTO_MODE, 32'd0);
		send_request(make_req(REQ_TIMED, RAD_SPAN, ONE_Q, 32'd100, '0));
		send_request(make_req(REQ_DIRECT, RAD_SPAN, ONE_Q, 32'd100, '0));
		send_request(make_req(REQ_INIT, -RAD_SPAN, ONE_Q, 32'd100, 5 * ONE_Q));
		wait_idle();

		// reverse acting, full-scale gains, widest limits, zero sample period
		apb_write(REG_AUTO_MODE, 32'd1);
		apb_write(REG_REVERSE, 32'd1);
		apb_write(REG_PROP_GAIN, GAIN_MAX);
		apb_write(REG_INTEG_GAIN, GAIN_MAX);
		apb_write(REG_DERIV_GAIN, GAIN_MAX);
		apb_write(REG_OUT_MIN, MIN_Q);
		apb_write(REG_OUT_MAX, MAX_Q);
		apb_write(REG_PERIOD, 32'd0);
		send_request(make_req(REQ_TIMED, 32'sd5000, -ONE_Q, 32'd100, '0));
		send_request(make_req(REQ_TIMED, -32'sd5000, ONE_Q, 32'd100, '0));
		send_request(make_req(REQ_DIRECT, 32'sd1, 32'sd0, 32'd100, '0));
		wait_idle();

		// crossed limits, written so each write clamps held drive and integral at once
		apb_write(REG_REVERSE, 32'd0);
		apb_write(REG_PROP_GAIN, ONE_Q);
		apb_write(REG_INTEG_GAIN, ONE_Q);
		apb_write(REG_DERIV_GAIN, 32'd0);
		apb_write(REG_OUT_MAX, -10 * ONE_Q);
		apb_write(REG_OUT_MIN, 10 * ONE_Q);
		apb_write(REG_PERIOD, 32'd65535);
		send_request(make_req(REQ_DIRECT, RAD_SPAN / 3, DEG_SPAN / 3, 32'd150, '0));
		send_request(make_req(REQ_TIMED, RAD_SPAN / 3, DEG_SPAN / 3, 32'd200, '0));
		send_request(make_req(REQ_INIT, '0, '0, 32'd200, '0));

		// random part in three idling phases, fresh setting every block
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 6;
					rx_idle_pct = 48;
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct = 6;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				if (n % BLOCK_ITEMS == 0) begin
					wait_idle();
					randomize_config();
				end
				send_request(random_req());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (loop_model.mismatches == 0) begin
			$display("pid_controller_step_tb: PASS");
		end else begin
			$display("pid_controller_step_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/pidc_pkg.sv
sv/pidc_in_if.sv
sv/pidc_out_if.sv
sv/pidc_regs.sv
sv/pidc_seq.sv
sv/pidc_dp.sv
sv/pid_controller_step.sv
sim/pid_controller_step_tb.sv
